// ===== design/pds_pkg.sv =====
// Shared types and constants for the path dash stroker.
`default_nettype none
package pds_pkg;

	localparam int PATTERN_SIZE = 4;
	localparam int IDX_W        = $clog2(PATTERN_SIZE);
	localparam int MAX_PIECES   = 64;
	localparam int CNT_W        = $clog2(MAX_PIECES + 1);

	// configuration register indexes
	localparam logic [2:0] REG_COUNT  = 3'd0;
	localparam logic [2:0] REG_OFFSET = 3'd1;
	localparam logic [2:0] REG_LEN0   = 3'd2;
	localparam logic [2:0] REG_LEN1   = 3'd3;
	localparam logic [2:0] REG_LEN2   = 3'd4;
	localparam logic [2:0] REG_LEN3   = 3'd5;

	typedef enum logic [1:0] {
		ACT_MOVE  = 2'd0,
		ACT_LINE  = 2'd1,
		ACT_CUBIC = 2'd2,
		ACT_CLOSE = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		AR_MULDIV = 2'd0,
		AR_MOD    = 2'd1,
		AR_SQRT   = 2'd2
	} ar_op_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic setup;
		logic move;
		logic emit_one;
		logic sq_x;
		logic sq_y;
		logic sqrt_go;
		logic set_len;
		logic step;
		logic set_trunc;
		logic push;
		logic lerp_go;
		logic lerp_store;
		logic advance;
		logic boundary;
		logic mod_go;
		logic mod_store;
		logic flush;
		logic finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		act_t action;
		logic dashed;
		logic out_free;
		logic ar_done;
		logic root_zero;
		logic pos_lt_len;
		logic in_dash;
		logic phase_on;
		logic cnt_full;
		logic cnt_zero;
		logic lerp_last;
		logic adv_lt_rem;
		logic skip;
	} sts_t;

endpackage
`default_nettype wire

// ===== design/pds_arith.sv =====
// Iterative arithmetic unit: rounded multiply-divide, modulo and square root.
`default_nettype none
module pds_arith
	import pds_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire ar_op_t       op,
	input  wire logic [32:0]  a,
	input  wire logic [32:0]  b,
	input  wire logic [32:0]  c,
	input  wire logic [63:0]  rad,
	output logic              done,
	output logic [32:0]       res
);

	typedef enum logic [4:0] {
		A_IDLE = 5'b00001,
		A_MUL  = 5'b00010,
		A_ADD  = 5'b00100,
		A_DIV  = 5'b01000,
		A_SQRT = 5'b10000
	} ast_t;

	ast_t        state_q;
	logic        done_q;
	logic        mod_q;
	logic [5:0]  cnt_q;
	logic [32:0] a_q;
	logic [32:0] c_q;
	logic [66:0] prod_q;
	logic [33:0] rem_q;
	logic [32:0] quo_q;

	logic [33:0] mul_sum;
	logic [66:0] add_n;
	logic [33:0] div_sh;
	logic        div_ge;
	logic [35:0] sq_sh;
	logic [33:0] sq_trial;
	logic        sq_ge;

	always_comb begin
		mul_sum  = prod_q[66:33] + (prod_q[0] ? {1'b0, a_q} : 34'd0);
		add_n    = prod_q + {34'd0, 1'b0, c_q[32:1]};
		div_sh   = {rem_q[32:0], prod_q[66]};
		div_ge   = div_sh >= {1'b0, c_q};
		sq_sh    = {rem_q, prod_q[66:65]};
		sq_trial = {quo_q[31:0], 2'b01};
		sq_ge    = sq_sh >= {2'b00, sq_trial};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
			mod_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (go) begin
						unique case (op)
							AR_MOD: begin
								mod_q   <= 1'b1;
								cnt_q   <= 6'd33;
								state_q <= A_DIV;
							end
							AR_SQRT: begin
								mod_q   <= 1'b0;
								cnt_q   <= 6'd32;
								state_q <= A_SQRT;
							end
							default: begin
								mod_q   <= 1'b0;
								cnt_q   <= 6'd33;
								state_q <= A_MUL;
							end
						endcase
					end
				end
				A_MUL: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) state_q <= A_ADD;
				end
				A_ADD: begin
					cnt_q   <= 6'd33;
					state_q <= A_DIV;
				end
				A_DIV, A_SQRT: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= A_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				if (go) begin
					a_q   <= a;
					c_q   <= c;
					quo_q <= '0;
					rem_q <= '0;
					unique case (op)
						AR_MOD:  prod_q <= {a, 34'd0};
						AR_SQRT: prod_q <= {rad, 3'd0};
						default: prod_q <= {34'd0, b};
					endcase
				end
			end
			A_MUL: prod_q <= {1'b0, mul_sum, prod_q[32:1]};
			A_ADD: begin
				rem_q  <= add_n[66:33];
				prod_q <= {add_n[32:0], 34'd0};
				quo_q  <= '0;
			end
			A_DIV: begin
				rem_q  <= div_ge ? (div_sh - {1'b0, c_q}) : div_sh;
				quo_q  <= {quo_q[31:0], div_ge};
				prod_q <= {prod_q[65:0], 1'b0};
			end
			A_SQRT: begin
				rem_q  <= sq_ge ? 34'(sq_sh - {2'b00, sq_trial}) : sq_sh[33:0];
				quo_q  <= {quo_q[31:0], sq_ge};
				prod_q <= {prod_q[64:0], 2'b00};
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = mod_q ? rem_q[32:0] : quo_q;

endmodule
`default_nettype wire

// ===== design/pds_dp.sv =====
// Datapath: configuration, path state, dash walk registers and output register.
`default_nettype none
module pds_dp
	import pds_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [23:0]  cfg_data,
	input  wire logic [191:0] s_tdata,
	input  wire logic [1:0]   s_tuser,
	input  wire cmd_t         cmd,
	output sts_t              sts,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [255:0]      m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);

	// configuration
	logic [2:0]  dash_count_q;
	logic [23:0] dash_offset_q;
	logic [23:0] dash_len_q [PATTERN_SIZE];

	// path and phase state
	logic signed [31:0] cur_x_q, cur_y_q;
	logic [23:0]        phase_pos_q;
	logic [IDX_W-1:0]   phase_idx_q;
	logic               phase_on_q;

	// current item
	act_t               act_q;
	logic signed [31:0] px_q, py_q, cax_q, cay_q, cbx_q, cby_q;

	// line walk
	logic [32:0]        mx_q, my_q;
	logic               negx_q, negy_q, sh_q;
	logic [63:0]        sqx_q, sqy_q;
	logic [32:0]        len_q, pos_q, adv_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               trunc_q;
	logic [1:0]         sel_q;
	logic [31:0]        piece_q [4];

	// output register
	logic               o_valid_q;
	logic [255:0]       o_data_q;
	logic [1:0]         o_user_q;
	logic               o_last_q;

	// arithmetic unit
	logic               ar_go, ar_done;
	ar_op_t             ar_op;
	logic [32:0]        ar_a, ar_b, ar_c, ar_res;

	logic [2:0]         n_c;
	logic [25:0]        period_c;
	logic [26:0]        q_c;
	logic               vis_zero;
	logic signed [32:0] dx_c, dy_c;
	logic [32:0]        magx_c, magy_c;
	logic [31:0]        mxs_c, mys_c;
	logic [23:0]        el_c, rem_e;
	logic [32:0]        left_c, adv_c;
	logic               in_dash;
	logic [31:0]        off_c, base_c, coord_c;
	logic               neg_c;
	logic               out_free;
	logic [IDX_W-1:0]   jj;
	logic [IDX_W:0]     idx_nx;

	always_comb begin
		n_c      = (dash_count_q > 3'(PATTERN_SIZE)) ? 3'(PATTERN_SIZE) : dash_count_q;
		period_c = '0;
		vis_zero = ~n_c[0];
		jj       = '0;
		for (int i = 0; i < PATTERN_SIZE; i++) begin
			jj = IDX_W'(i);
			if (3'(i) < n_c) begin
				period_c = period_c + 26'(dash_len_q[i]);
				// visible entries of one cycle from the current boundary
				if ((phase_on_q ^ (jj[0] ^ phase_idx_q[0])) && dash_len_q[i] != 24'd0)
					vis_zero = 1'b0;
			end
		end
		q_c = n_c[0] ? {period_c, 1'b0} : {1'b0, period_c};

		dx_c   = 33'(px_q) - 33'(cur_x_q);
		dy_c   = 33'(py_q) - 33'(cur_y_q);
		magx_c = dx_c[32] ? 33'(-dx_c) : 33'(dx_c);
		magy_c = dy_c[32] ? 33'(-dy_c) : 33'(dy_c);
		mxs_c  = 32'(mx_q >> sh_q);
		mys_c  = 32'(my_q >> sh_q);

		el_c    = dash_len_q[phase_idx_q];
		in_dash = phase_pos_q < el_c;
		rem_e   = el_c - phase_pos_q;
		left_c  = len_q - pos_q;
		adv_c   = ({9'd0, rem_e} < left_c) ? {9'd0, rem_e} : left_c;
		idx_nx  = {1'b0, phase_idx_q} + 1'b1;

		off_c   = ar_res[31:0];
		neg_c   = sel_q[0] ? negy_q : negx_q;
		base_c  = sel_q[0] ? cur_y_q : cur_x_q;
		coord_c = neg_c ? (base_c - off_c) : (base_c + off_c);

		out_free = ~o_valid_q | m_tready;

		ar_go = cmd.sqrt_go | cmd.lerp_go | cmd.mod_go;
		if (cmd.sqrt_go)     ar_op = AR_SQRT;
		else if (cmd.mod_go) ar_op = AR_MOD;
		else                 ar_op = AR_MULDIV;
		ar_a = cmd.mod_go ? left_c : (sel_q[0] ? my_q : mx_q);
		ar_b = pos_q + (sel_q[1] ? adv_q : 33'd0);
		ar_c = cmd.mod_go ? {6'd0, q_c} : len_q;
	end

	pds_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (ar_go),
		.op     (ar_op),
		.a      (ar_a),
		.b      (ar_b),
		.c      (ar_c),
		.rad    (sqx_q + sqy_q),
		.done   (ar_done),
		.res    (ar_res)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dash_count_q  <= '0;
			dash_offset_q <= '0;
			for (int i = 0; i < PATTERN_SIZE; i++) dash_len_q[i] <= '0;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			phase_pos_q <= '0;
			phase_idx_q <= '0;
			phase_on_q  <= 1'b1;
			o_valid_q   <= 1'b0;
			cnt_q       <= '0;
			trunc_q     <= 1'b0;
			sel_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_COUNT:  dash_count_q  <= cfg_data[2:0];
					REG_OFFSET: dash_offset_q <= cfg_data;
					REG_LEN0:   dash_len_q[0] <= cfg_data;
					REG_LEN1:   dash_len_q[1] <= cfg_data;
					REG_LEN2:   dash_len_q[2] <= cfg_data;
					REG_LEN3:   dash_len_q[3] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.move) begin
				cur_x_q     <= px_q;
				cur_y_q     <= py_q;
				phase_pos_q <= dash_offset_q;
				phase_idx_q <= '0;
				phase_on_q  <= 1'b1;
			end
			if (cmd.finish) begin
				cur_x_q <= px_q;
				cur_y_q <= py_q;
			end
			if (cmd.set_len) begin
				cnt_q   <= '0;
				trunc_q <= 1'b0;
				sel_q   <= '0;
				if (ar_res != 33'd0 && {1'b0, phase_idx_q} >= n_c) phase_idx_q <= '0;
			end
			if (cmd.set_trunc) trunc_q <= 1'b1;
			if (cmd.lerp_store) begin
				sel_q <= sel_q + 2'd1;
				if (sel_q == 2'd3) cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.advance) phase_pos_q <= phase_pos_q + adv_q[23:0];
			if (cmd.boundary) begin
				phase_pos_q <= '0;
				phase_idx_q <= (idx_nx == {1'b0, n_c}) ? '0 : idx_nx[IDX_W-1:0];
				phase_on_q  <= ~phase_on_q;
			end
			if (cmd.emit_one || cmd.push || cmd.flush) o_valid_q <= 1'b1;
			else if (m_tready)                         o_valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= act_t'(s_tuser);
			px_q  <= s_tdata[31:0];
			py_q  <= s_tdata[63:32];
			cax_q <= s_tdata[95:64];
			cay_q <= s_tdata[127:96];
			cbx_q <= s_tdata[159:128];
			cby_q <= s_tdata[191:160];
		end
		if (cmd.setup) begin
			mx_q   <= magx_c;
			my_q   <= magy_c;
			negx_q <= dx_c[32];
			negy_q <= dy_c[32];
			sh_q   <= magx_c[32] | magx_c[31] | magy_c[32] | magy_c[31];
		end
		if (cmd.sq_x) sqx_q <= mxs_c * mxs_c;
		if (cmd.sq_y) sqy_q <= mys_c * mys_c;
		if (cmd.set_len) begin
			len_q <= {1'b0, ar_res[31:0]} << sh_q;
			pos_q <= '0;
		end
		if (cmd.step)       adv_q <= adv_c;
		if (cmd.advance)    pos_q <= pos_q + adv_q;
		if (cmd.mod_store)  pos_q <= len_q - ar_res;
		if (cmd.lerp_store) piece_q[sel_q] <= coord_c;
		if (cmd.emit_one) begin
			if (act_q == ACT_CUBIC)
				o_data_q <= {cby_q, cbx_q, cay_q, cax_q, py_q, px_q, cur_y_q, cur_x_q};
			else
				o_data_q <= {128'd0, py_q, px_q, cur_y_q, cur_x_q};
			o_user_q <= {1'b0, act_q == ACT_CUBIC};
			o_last_q <= 1'b1;
		end
		if (cmd.push || cmd.flush) begin
			o_data_q <= {128'd0, piece_q[3], piece_q[2], piece_q[1], piece_q[0]};
			o_user_q <= {cmd.flush & trunc_q, 1'b0};
			o_last_q <= cmd.flush;
		end
	end

	always_comb begin
		sts.action     = act_q;
		sts.dashed     = (n_c >= 3'd2) && (period_c != '0);
		sts.out_free   = out_free;
		sts.ar_done    = ar_done;
		sts.root_zero  = ar_res == 33'd0;
		sts.pos_lt_len = pos_q < len_q;
		sts.in_dash    = in_dash;
		sts.phase_on   = phase_on_q;
		sts.cnt_full   = cnt_q == CNT_W'(MAX_PIECES);
		sts.cnt_zero   = cnt_q == '0;
		sts.lerp_last  = sel_q == 2'd3;
		sts.adv_lt_rem = adv_q < {9'd0, rem_e};
		sts.skip       = (pos_q < len_q) && (left_c >= {6'd0, q_c}) && (trunc_q | vis_zero);
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = o_data_q;
	assign m_tuser  = o_user_q;
	assign m_tlast  = o_last_q;

endmodule
`default_nettype wire

// ===== design/pds_ctrl.sv =====
// Controller state machine sequencing decode, line length and the dash walk.
`default_nettype none
module pds_ctrl
	import pds_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [17:0] {
		S_IDLE   = 18'h00001,
		S_DECODE = 18'h00002,
		S_ONE    = 18'h00004,
		S_SQX    = 18'h00008,
		S_SQY    = 18'h00010,
		S_SQRT   = 18'h00020,
		S_SQWT   = 18'h00040,
		S_STEP   = 18'h00080,
		S_PUSH   = 18'h00100,
		S_LGO    = 18'h00200,
		S_LWT    = 18'h00400,
		S_ADV    = 18'h00800,
		S_BOUND  = 18'h01000,
		S_SKIP   = 18'h02000,
		S_MGO    = 18'h04000,
		S_MWT    = 18'h08000,
		S_FLUSH  = 18'h10000,
		S_FIN    = 18'h20000
	} st_t;

	st_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.setup = 1'b1;
				unique case (sts.action)
					ACT_MOVE: begin
						cmd.move = 1'b1;
						state_d  = S_IDLE;
					end
					ACT_LINE:  state_d = sts.dashed ? S_SQX : S_ONE;
					ACT_CUBIC: state_d = S_ONE;
					default:   state_d = S_IDLE;
				endcase
			end
			S_ONE: begin
				if (sts.out_free) begin
					cmd.emit_one = 1'b1;
					state_d      = S_FIN;
				end
			end
			S_SQX: begin
				cmd.sq_x = 1'b1;
				state_d  = S_SQY;
			end
			S_SQY: begin
				cmd.sq_y = 1'b1;
				state_d  = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_go = 1'b1;
				state_d     = S_SQWT;
			end
			S_SQWT: begin
				if (sts.ar_done) begin
					cmd.set_len = 1'b1;
					state_d     = sts.root_zero ? S_FIN : S_STEP;
				end
			end
			S_STEP: begin
				cmd.step = 1'b1;
				priority if (!sts.pos_lt_len) state_d = sts.cnt_zero ? S_FIN : S_FLUSH;
				else if (!sts.in_dash)        state_d = S_BOUND;
				else if (sts.phase_on && !sts.cnt_full)
					state_d = sts.cnt_zero ? S_LGO : S_PUSH;
				else begin
					cmd.set_trunc = sts.phase_on;
					state_d       = S_ADV;
				end
			end
			S_PUSH: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_LGO;
				end
			end
			S_LGO: begin
				cmd.lerp_go = 1'b1;
				state_d     = S_LWT;
			end
			S_LWT: begin
				if (sts.ar_done) begin
					cmd.lerp_store = 1'b1;
					state_d        = sts.lerp_last ? S_ADV : S_LGO;
				end
			end
			S_ADV: begin
				cmd.advance = 1'b1;
				state_d     = sts.adv_lt_rem ? S_STEP : S_BOUND;
			end
			S_BOUND: begin
				cmd.boundary = 1'b1;
				state_d      = S_SKIP;
			end
			S_SKIP:  state_d = sts.skip ? S_MGO : S_STEP;
			S_MGO: begin
				cmd.mod_go = 1'b1;
				state_d    = S_MWT;
			end
			S_MWT: begin
				if (sts.ar_done) begin
					cmd.mod_store = 1'b1;
					state_d       = S_STEP;
				end
			end
			S_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_FIN;
				end
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule
`default_nettype wire

// ===== design/path_dash_stroker.sv =====
// Top level of the path dash stroker: controller plus datapath.
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tuser: action; tdata: point, two control points
// m_*      out  m_tvalid/m_tready  tuser: prim_kind, truncated; tdata: 8 coordinates
// cfg_*    in   cfg_we             cfg_index selects register, cfg_data value
//
// A solid line or cubic waits out any output stall.
// A dashed line first finds its length (two squares and a 32-step square root),
// then takes four operations of the shared bit-serial multiply-divide unit per
// visible piece, plus a modulo step at a dash boundary when whole periods are skipped.
// Reset clears configuration, current point and phase; the block is ready at once.
// A stalled output holds the walk; one piece waits in the piece registers.
`default_nettype none
module path_dash_stroker
	import pds_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [191:0] s_tdata,  // point_x, point_y, ctrl_a_x, ctrl_a_y, ctrl_b_x, ctrl_b_y
	input  wire logic [1:0]   s_tuser,  // action
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [255:0]      m_tdata,  // start_x, start_y, end_x, end_y, bez_a_x, bez_a_y,
	                                    // bez_b_x, bez_b_y
	output logic [1:0]        m_tuser,  // prim_kind, truncated
	output logic              m_tlast,  // last_piece
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [23:0]  cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// sequencer: decode, length, dash walk, output handoff
	pds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// registers, arithmetic unit and the output register
	pds_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire
